// ===== rtl/core/imu_hf_pkg.sv =====
// shared types and constants for the imu frame parser and heading filter
package imu_hf_pkg;

   localparam int FRAME_LEN    = 11;
   localparam int STORED_BYTES = 10;
   localparam int COUNT_W      = 4;

   localparam logic [7:0] SYNC_BYTE  = 8'h55;
   localparam logic [7:0] ANGLE_TYPE = 8'h53;

   localparam int YAW_W       = 16;
   localparam int HEADING_W   = 9;
   localparam int HEADING_MOD = 360;
   localparam int SCALE_MUL   = 60;
   localparam int SCALE_SHIFT = 15;

   localparam int OUTQ_DEPTH = 4;
   localparam int LOAD_W     = 3;

   typedef struct packed {
      logic [7:0]  frame_type;
      logic [15:0] word_a;
      logic [15:0] word_b;
      logic [15:0] word_c;
      logic [15:0] word_d;
      logic        is_angle;
   } frame_item_type;

   typedef struct packed {
      logic [7:0]           frame_type;
      logic [15:0]          word_a;
      logic [15:0]          word_b;
      logic [15:0]          word_c;
      logic [15:0]          word_d;
      logic [HEADING_W-1:0] heading_deg;
      logic                 heading_new;
   } result_item_type;

   typedef struct packed {
      logic frame_done;
      logic frame_busy;
   } asm_status_type;

endpackage

// ===== rtl/core/imu_frame_parser_heading_filter.sv =====
// Takes one serial byte per cycle while req_stall is low and emits one
// transaction per 11-byte frame that opens with 0x55 (bytes outside a frame
// that are not 0x55 are dropped; the checksum byte is not checked). The result
// carries the frame type, the four little-endian payload words and the heading
// in whole degrees: on angle frames (type 0x53) the yaw word enters a
// WINDOW_LEN-entry window and the heading is the window sum less its largest
// and smallest entries, times 60, over 32768 truncated toward zero, modulo
// 360; other frames repeat the last heading with heading_new low. Bytes are
// taken back to back, one per cycle, while req_stall is low. A result is
// offered once the frame's last byte has passed through the frame register and
// then the window update, trimmed sum, scaling and queue write registers.
// Results wait in a 4-entry queue; req_stall rises only when that queue and
// the results still in the pipe fill it, i.e. when the receiver holds off.
module imu_frame_parser_heading_filter
   import imu_hf_pkg::*;
#(
   parameter int WINDOW_LEN = 5
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_frame_type,
   output logic [15:0]          rsp_word_a,
   output logic [15:0]          rsp_word_b,
   output logic [15:0]          rsp_word_c,
   output logic [15:0]          rsp_word_d,
   output logic [HEADING_W-1:0] rsp_heading_deg,
   output logic                 rsp_heading_new
);

   logic              req_accept;
   frame_item_type    frame;
   asm_status_type    asm_status;
   logic              res_valid;
   result_item_type   res_item;
   logic [1:0]        inflight;
   logic [LOAD_W-1:0] pipe_load;
   result_item_type   head_item;

   assign req_accept = req_valid && !req_stall;

   imu_hf_assembler u_assembler (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .rx_byte    (req_rx_byte),
      .frame_o    (frame),
      .status     (asm_status)
   );

   imu_hf_filter #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_filter (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (asm_status.frame_busy),
      .frame_i     (frame),
      .res_valid   (res_valid),
      .res_o       (res_item),
      .inflight    (inflight)
   );

   // results not yet in the queue, counting a frame closing this cycle
   assign pipe_load = LOAD_W'(asm_status.frame_busy) + LOAD_W'(asm_status.frame_done)
                    + LOAD_W'(inflight);

   imu_hf_outq #(
      .DEPTH (OUTQ_DEPTH)
   ) u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_item (res_item),
      .pipe_load (pipe_load),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head_item (head_item)
   );

   assign rsp_frame_type  = head_item.frame_type;
   assign rsp_word_a      = head_item.word_a;
   assign rsp_word_b      = head_item.word_b;
   assign rsp_word_c      = head_item.word_c;
   assign rsp_word_d      = head_item.word_d;
   assign rsp_heading_deg = head_item.heading_deg;
   assign rsp_heading_new = head_item.heading_new;

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heading_deg < HEADING_W'(HEADING_MOD)))
      else $error("heading out of range");

   a_new_on_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heading_new == (rsp_frame_type == ANGLE_TYPE)))
      else $error("heading_new does not match frame type");

   a_frames_apart: assert property (@(posedge clock) disable iff (reset)
      asm_status.frame_done |=> !asm_status.frame_done)
      else $error("frames closed on consecutive cycles");

   a_no_close_when_full: assert property (@(posedge clock) disable iff (reset)
      asm_status.frame_done |-> !req_stall)
      else $error("frame closed while input stalled");

endmodule

// ===== rtl/core/imu_hf_assembler.sv =====
// byte collector: syncs on the start byte and assembles one frame
module imu_hf_assembler
   import imu_hf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_accept,
   input  logic [7:0]     rx_byte,
   output frame_item_type frame_o,
   output asm_status_type status
);

   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [7:0]         frame_bytes_ff [STORED_BYTES];
   logic               store_en;
   frame_item_type     frame_ff, frame_in;
   logic               frame_valid_ff, frame_valid_in;
   logic               frame_done;

   always_comb begin
      byte_count_in  = byte_count_ff;
      frame_in       = frame_ff;
      frame_valid_in = 1'b0;
      store_en       = 1'b0;
      frame_done     = 1'b0;
      // a non-sync byte outside a frame is dropped
      if (req_accept && !(byte_count_ff == '0 && rx_byte != SYNC_BYTE)) begin
         if (byte_count_ff == COUNT_W'(FRAME_LEN - 1)) begin
            // checksum byte closes the frame, not stored
            byte_count_in       = '0;
            frame_done          = 1'b1;
            frame_valid_in      = 1'b1;
            frame_in.frame_type = frame_bytes_ff[1];
            frame_in.word_a     = {frame_bytes_ff[3], frame_bytes_ff[2]};
            frame_in.word_b     = {frame_bytes_ff[5], frame_bytes_ff[4]};
            frame_in.word_c     = {frame_bytes_ff[7], frame_bytes_ff[6]};
            frame_in.word_d     = {frame_bytes_ff[9], frame_bytes_ff[8]};
            frame_in.is_angle   = (frame_bytes_ff[1] == ANGLE_TYPE);
         end else begin
            byte_count_in = byte_count_ff + COUNT_W'(1);
            store_en      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         frame_valid_ff <= 1'b0;
      end else begin
         byte_count_ff  <= byte_count_in;
         frame_valid_ff <= frame_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         frame_bytes_ff[byte_count_ff] <= rx_byte;
      end
      frame_ff <= frame_in;
   end

   assign frame_o           = frame_ff;
   assign status.frame_done = frame_done;
   assign status.frame_busy = frame_valid_ff;

endmodule

// ===== rtl/core/imu_hf_filter.sv =====
// yaw window, trimmed sum, scaling to degrees and heading result
module imu_hf_filter
   import imu_hf_pkg::*;
#(
   parameter int WINDOW_LEN = 5
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            frame_valid,
   input  frame_item_type  frame_i,
   output logic            res_valid,
   output result_item_type res_o,
   output logic [1:0]      inflight
);

   localparam int SLOT_W     = $clog2(WINDOW_LEN);
   localparam int SUM_W      = YAW_W + $clog2(WINDOW_LEN) + 1;
   localparam int PROD_W     = SUM_W + 6;
   localparam int Q_W        = PROD_W - SCALE_SHIFT;
   localparam int QMAX       = (WINDOW_LEN - 2) * SCALE_MUL;
   localparam int MOD_BIAS   = HEADING_MOD * ((QMAX + HEADING_MOD - 1) / HEADING_MOD);
   localparam int MOD_STEPS  = (MOD_BIAS + QMAX) / HEADING_MOD;
   localparam int EXT_W      = Q_W + 2;
   localparam int FIRST_SLOT = 1 % WINDOW_LEN;
   localparam int ROUND_ADD  = (1 << SCALE_SHIFT) - 1;

   logic signed [YAW_W-1:0] window_ff [WINDOW_LEN];
   logic signed [YAW_W-1:0] window_in [WINDOW_LEN];
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic                    primed_ff, primed_in;

   logic                    p1_valid_ff, p2_valid_ff, p3_valid_ff;
   frame_item_type          p1_ff, p2_ff, p3_ff;

   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [Q_W-1:0]   q_ff, q_in;
   logic [HEADING_W-1:0]    last_heading_ff, last_heading_in;

   logic signed [SUM_W-1:0]  acc;
   logic signed [YAW_W-1:0]  hi, lo;
   logic signed [PROD_W-1:0] prod, rnd;
   logic signed [EXT_W-1:0]  wrap;
   logic [HEADING_W-1:0]     heading;

   // window update as the frame enters
   always_comb begin
      window_in = window_ff;
      slot_in   = slot_ff;
      primed_in = primed_ff;
      if (frame_valid && frame_i.is_angle) begin
         if (!primed_ff) begin
            for (int k = 0; k < WINDOW_LEN; k++) begin
               window_in[k] = signed'(frame_i.word_c);
            end
            slot_in   = SLOT_W'(FIRST_SLOT);
            primed_in = 1'b1;
         end else begin
            window_in[slot_ff] = signed'(frame_i.word_c);
            slot_in = (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_ff + SLOT_W'(1);
         end
      end
   end

   // sum without the largest and smallest entry
   always_comb begin
      acc = '0;
      hi  = window_ff[0];
      lo  = window_ff[0];
      for (int k = 0; k < WINDOW_LEN; k++) begin
         acc = acc + SUM_W'(window_ff[k]);
         if (window_ff[k] > hi) begin
            hi = window_ff[k];
         end
         if (window_ff[k] < lo) begin
            lo = window_ff[k];
         end
      end
      sum_in = acc - SUM_W'(hi) - SUM_W'(lo);
   end

   // times 60 over 32768, truncated toward zero
   always_comb begin
      prod = PROD_W'(sum_ff) * PROD_W'(SCALE_MUL);
      if (prod[PROD_W-1]) begin
         rnd = (prod + PROD_W'(ROUND_ADD)) >>> SCALE_SHIFT;
      end else begin
         rnd = prod >>> SCALE_SHIFT;
      end
      q_in = Q_W'(rnd);
   end

   // true modulo 360: bias to non-negative, then MOD_STEPS compare-subtracts
   always_comb begin
      wrap = EXT_W'(q_ff) + EXT_W'(MOD_BIAS);
      for (int k = 0; k < MOD_STEPS; k++) begin
         if (wrap >= EXT_W'(HEADING_MOD)) begin
            wrap = wrap - EXT_W'(HEADING_MOD);
         end
      end
      heading = wrap[HEADING_W-1:0];

      last_heading_in = last_heading_ff;
      if (p3_valid_ff && p3_ff.is_angle) begin
         last_heading_in = heading;
      end

      res_o.frame_type  = p3_ff.frame_type;
      res_o.word_a      = p3_ff.word_a;
      res_o.word_b      = p3_ff.word_b;
      res_o.word_c      = p3_ff.word_c;
      res_o.word_d      = p3_ff.word_d;
      res_o.heading_deg = p3_ff.is_angle ? heading : last_heading_ff;
      res_o.heading_new = p3_ff.is_angle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff         <= '0;
         primed_ff       <= 1'b0;
         p1_valid_ff     <= 1'b0;
         p2_valid_ff     <= 1'b0;
         p3_valid_ff     <= 1'b0;
         last_heading_ff <= '0;
      end else begin
         slot_ff         <= slot_in;
         primed_ff       <= primed_in;
         p1_valid_ff     <= frame_valid;
         p2_valid_ff     <= p1_valid_ff;
         p3_valid_ff     <= p2_valid_ff;
         last_heading_ff <= last_heading_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      p1_ff     <= frame_i;
      p2_ff     <= p1_ff;
      p3_ff     <= p2_ff;
      sum_ff    <= sum_in;
      q_ff      <= q_in;
   end

   assign res_valid = p3_valid_ff;
   assign inflight  = 2'(p1_valid_ff) + 2'(p2_valid_ff) + 2'(p3_valid_ff);

endmodule

// ===== rtl/core/imu_hf_outq.sv =====
// result queue with credit-based input stall
module imu_hf_outq
   import imu_hf_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  result_item_type   push_item,
   input  logic [LOAD_W-1:0] pipe_load,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output result_item_type   head_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int OCC_W = ((CNT_W > LOAD_W) ? CNT_W : LOAD_W) + 1;

   result_item_type   entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              stall_ff, stall_in;
   logic              pop;
   logic [OCC_W-1:0]  occ;

   always_comb begin
      pop       = (count_ff != '0) && !rsp_stall;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      // results queued or still in the pipe after this edge
      occ      = OCC_W'(count_ff) + OCC_W'(pipe_load) - OCC_W'(pop);
      stall_in = (occ >= OCC_W'(DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         stall_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         stall_ff  <= stall_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign req_stall = stall_ff;
   assign rsp_valid = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];

endmodule
